// ===== rtl/gbn_pkg.sv =====
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int unsigned SEQ_W   = 3;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TIMER_W = 20;

  localparam logic [TIMER_W-1:0] TIMER_MAX     = {TIMER_W{1'b1}};
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(800000);

  // operation codes of an input item
  localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
  localparam logic [OP_W-1:0] OP_SEND  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // kinds of result item
  localparam logic [KIND_W-1:0] KIND_TX      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd2;

  typedef enum logic [1:0] {
    TMR_NONE,
    TMR_CLEAR,
    TMR_AGE
  } tmr_cmd_e;

  typedef struct packed {
    tmr_cmd_e         cmd;
    logic [SEQ_W-1:0] idx;
  } tmr_req_t;

endpackage

// ===== rtl/gbn_in_if.sv =====
`timescale 1ns / 1ps

interface gbn_in_if #(
  parameter int unsigned PAYLOAD_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [2:0]              rx_seq;
  logic [2:0]              rx_ack;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, operation, rx_seq, rx_ack, payload, input ready);
  modport sink   (input valid, operation, rx_seq, rx_ack, payload, output ready);
endinterface

// ===== rtl/gbn_out_if.sv =====
`timescale 1ns / 1ps

interface gbn_out_if #(
  parameter int unsigned PAYLOAD_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [2:0]              tx_seq;
  logic [2:0]              tx_ack;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic                    last;

  modport source (output valid, kind, tx_seq, tx_ack, out_payload, last, input ready);
  modport sink   (input valid, kind, tx_seq, tx_ack, out_payload, last, output ready);
endinterface

// ===== rtl/gbn_timer_unit.sv =====
`timescale 1ns / 1ps

module gbn_timer_unit #(
  parameter int unsigned N_SLOTS = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbn_pkg::tmr_req_t             req_i,
  input  logic [gbn_pkg::TIMER_W-1:0]   timeout_i,
  output logic                          hit_o
);
  import gbn_pkg::*;

  localparam int unsigned IDX_W = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1;

  logic [TIMER_W-1:0] timer_q [N_SLOTS];
  logic [IDX_W-1:0]   idx;
  logic [TIMER_W-1:0] cur;
  logic [TIMER_W-1:0] nxt;

  // one saturating incrementer and one compare, shared by every slot
  assign idx   = req_i.idx[IDX_W-1:0];
  assign cur   = timer_q[idx];
  assign nxt   = (cur == TIMER_MAX) ? cur : cur + 1'b1;
  assign hit_o = (nxt >= timeout_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N_SLOTS; k++) begin
        timer_q[k] <= '0;
      end
    end else begin
      unique case (req_i.cmd)
        TMR_CLEAR: timer_q[idx] <= '0;
        TMR_AGE:   timer_q[idx] <= nxt;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/go_back_n_link_controller.sv =====
`timescale 1ns / 1ps

// go-back-n link endpoint with piggybacked acks
// in_i carries items from the link (frame arrived), the application (payload
// to send) and a tick source; out_o carries transmit, deliver and refused
// results, with last set on the final result caused by an item.
// cfg_we_i/cfg_data_i write the timeout in ticks; write only while idle.
// a frame item is taken into a pending register, and its deliver result, if
// any, moves to the output register once that is free; a send item likewise
// gives one result. a tick walks the outstanding frames through the single
// shared timer incrementer, one frame a cycle, then on expiry resends them
// oldest first, each by a payload store read, then an output load.
// ready is low while an item is in work; one output register lets the
// sequencer finish while the receiver holds a result. a stalled receiver
// holds the sequencer at the next result, it never drops or repeats one.
// reset clears sequence state, counts and all timers, and sets the timeout
// to 800000 ticks; the payload store is not cleared and holds no meaning
// until a frame is sent.
module go_back_n_link_controller #(
  parameter int unsigned WINDOW       = 4,
  parameter int unsigned PAYLOAD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  gbn_in_if.sink                       in_i,
  gbn_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [gbn_pkg::TIMER_W-1:0]  cfg_data_i
);
  import gbn_pkg::*;

  localparam int unsigned SEQ_MOD = WINDOW + 1;
  localparam int unsigned IDX_W   = (SEQ_MOD > 1) ? $clog2(SEQ_MOD) : 1;
  localparam logic [SEQ_W-1:0] WIN_SEQ = SEQ_W'(WINDOW);
  localparam logic [SEQ_W:0]   MOD_EXT = (SEQ_W + 1)'(SEQ_MOD);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_TICK,
    S_READ,
    S_SEND
  } state_e;

  state_e                  state_q;
  logic [SEQ_W-1:0]        next_q, expected_q, oldest_q, count_q, walk_q;
  logic [TIMER_W-1:0]      timeout_q;
  logic                    expired_q;

  logic [KIND_W-1:0]       pend_kind_q;
  logic [SEQ_W-1:0]        pend_seq_q, pend_ack_q;
  logic [PAYLOAD_BITS-1:0] pend_pay_q;

  logic                    out_valid_q, out_last_q;
  logic [KIND_W-1:0]       out_kind_q;
  logic [SEQ_W-1:0]        out_seq_q, out_ack_q;
  logic [PAYLOAD_BITS-1:0] out_pay_q;

  logic [PAYLOAD_BITS-1:0] pay_mem [SEQ_MOD];
  logic [PAYLOAD_BITS-1:0] rd_q;

  logic                    in_acc, out_free, can_send, mem_we, walk_last, hit, retire;
  logic                    out_load;
  logic [SEQ_W-1:0]        ack_val, next_inc, expected_inc, walk_seq, new_count;
  logic [SEQ_W:0]          diff, old_sum, walk_sum;
  tmr_req_t                tmr_req;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = out_free && ((state_q == S_EMIT) || (state_q == S_SEND));
  assign can_send   = (count_q < WIN_SEQ);
  assign mem_we     = in_acc && (in_i.operation == OP_SEND) && can_send;

  assign ack_val      = (expected_q == '0) ? WIN_SEQ : expected_q - 1'b1;
  assign next_inc     = (next_q == WIN_SEQ) ? '0 : next_q + 1'b1;
  assign expected_inc = (expected_q == WIN_SEQ) ? '0 : expected_q + 1'b1;

  // cumulative ack: distance from the oldest frame, modulo window plus one
  always_comb begin
    if (in_i.rx_ack >= oldest_q) begin
      diff = {1'b0, in_i.rx_ack} - {1'b0, oldest_q};
    end else begin
      diff = {1'b0, in_i.rx_ack} + MOD_EXT - {1'b0, oldest_q};
    end
    old_sum = {1'b0, oldest_q} + diff + 1'b1;
    if (old_sum >= MOD_EXT) begin
      old_sum = old_sum - MOD_EXT;
    end
    walk_sum = {1'b0, oldest_q} + {1'b0, walk_q};
    if (walk_sum >= MOD_EXT) begin
      walk_sum = walk_sum - MOD_EXT;
    end
  end

  assign retire    = (in_i.rx_ack <= WIN_SEQ) && (diff < {1'b0, count_q});
  assign new_count = count_q - diff[SEQ_W-1:0] - 1'b1;
  assign walk_seq  = walk_sum[SEQ_W-1:0];
  assign walk_last = (walk_q == count_q - 1'b1);

  always_comb begin
    tmr_req.cmd = TMR_NONE;
    tmr_req.idx = walk_seq;
    if (mem_we) begin
      tmr_req.cmd = TMR_CLEAR;
      tmr_req.idx = next_q;
    end else if (state_q == S_TICK) begin
      tmr_req.cmd = TMR_AGE;
    end else if ((state_q == S_SEND) && out_free) begin
      tmr_req.cmd = TMR_CLEAR;
    end
  end

  gbn_timer_unit #(
    .N_SLOTS (SEQ_MOD)
  ) u_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tmr_req),
    .timeout_i (timeout_q),
    .hit_o     (hit)
  );

  // payload store, registered read at the walk position
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pay_mem[next_q[IDX_W-1:0]] <= in_i.payload;
    end
    rd_q <= pay_mem[walk_seq[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_q      <= '0;
      expected_q  <= '0;
      oldest_q    <= '0;
      count_q     <= '0;
      walk_q      <= '0;
      timeout_q   <= TIMEOUT_RESET;
      expired_q   <= 1'b0;
      pend_kind_q <= KIND_TX;
      pend_seq_q  <= '0;
      pend_ack_q  <= '0;
      pend_pay_q  <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_kind_q  <= KIND_TX;
      out_seq_q   <= '0;
      out_ack_q   <= '0;
      out_pay_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_i.operation)
              OP_FRAME: begin
                if (in_i.rx_seq == expected_q) begin
                  pend_kind_q <= KIND_DELIVER;
                  pend_seq_q  <= '0;
                  pend_ack_q  <= '0;
                  pend_pay_q  <= in_i.payload;
                  expected_q  <= expected_inc;
                  state_q     <= S_EMIT;
                end
                if (retire) begin
                  oldest_q <= old_sum[SEQ_W-1:0];
                  count_q  <= new_count;
                end
              end
              OP_SEND: begin
                if (can_send) begin
                  pend_kind_q <= KIND_TX;
                  pend_seq_q  <= next_q;
                  pend_ack_q  <= ack_val;
                  pend_pay_q  <= in_i.payload;
                  next_q      <= next_inc;
                  count_q     <= count_q + 1'b1;
                end else begin
                  pend_kind_q <= KIND_REFUSED;
                  pend_seq_q  <= '0;
                  pend_ack_q  <= '0;
                  pend_pay_q  <= '0;
                end
                state_q <= S_EMIT;
              end
              OP_TICK: begin
                if (count_q != '0) begin
                  walk_q    <= '0;
                  expired_q <= 1'b0;
                  state_q   <= S_TICK;
                end
              end
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_kind_q  <= pend_kind_q;
            out_seq_q   <= pend_seq_q;
            out_ack_q   <= pend_ack_q;
            out_pay_q   <= pend_pay_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_TICK: begin
          expired_q <= expired_q | hit;
          if (walk_last) begin
            walk_q  <= '0;
            state_q <= (expired_q || hit) ? S_READ : S_IDLE;
          end else begin
            walk_q <= walk_q + 1'b1;
          end
        end
        S_READ: begin
          state_q <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            out_kind_q  <= KIND_TX;
            out_seq_q   <= walk_seq;
            out_ack_q   <= ack_val;
            out_pay_q   <= rd_q;
            out_last_q  <= walk_last;
            if (walk_last) begin
              state_q <= S_IDLE;
            end else begin
              walk_q  <= walk_q + 1'b1;
              state_q <= S_READ;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.tx_seq      = out_seq_q;
  assign out_o.tx_ack      = out_ack_q;
  assign out_o.out_payload = out_pay_q;
  assign out_o.last        = out_last_q;

`ifndef SYNTHESIS
  a_count_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= WIN_SEQ)
    else $error("outstanding count beyond window");

  a_seq_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((({1'b0, oldest_q} + {1'b0, count_q}) >= MOD_EXT) ?
      (({1'b0, oldest_q} + {1'b0, count_q} - MOD_EXT) == {1'b0, next_q}) :
      (({1'b0, oldest_q} + {1'b0, count_q}) == {1'b0, next_q})))
    else $error("oldest plus outstanding does not match next sequence");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK || state_q == S_READ || state_q == S_SEND) |->
      (count_q != '0 && walk_q < count_q))
    else $error("walk index outside outstanding frames");

  a_resend_after_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK && walk_last && !expired_q && !hit) |=> state_q == S_IDLE)
    else $error("resend started without an expired timer");
`endif

endmodule

// ===== tb/go_back_n_link_controller_tb.sv =====
`timescale 1ns / 1ps

module go_back_n_link_controller_tb;
  import gbn_pkg::*;

  localparam int unsigned SEQ_MOD   = 5;
  localparam int unsigned LIMIT     = 300000;
  localparam int unsigned SETTLE    = 20;
  localparam int unsigned PHASE_LEN = 50;

  // operation code that the block ignores
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SEQ_W-1:0] rx_seq;
    logic [SEQ_W-1:0] rx_ack;
    logic [15:0]      payload;
  } link_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  ack;
    logic [15:0]       pay;
    logic              last;
  } link_res_t;

  typedef struct {
    bit                 is_cfg;
    link_item_t         it;
    bit                 typed;
    bit                 has_res;
    link_res_t          res;
    logic [TIMER_W-1:0] tmo_val;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [TIMER_W-1:0] cfg_data_i;

  gbn_in_if  #(.PAYLOAD_BITS(16)) in_ch ();
  gbn_out_if #(.PAYLOAD_BITS(16)) out_ch ();

  go_back_n_link_controller #(
    .WINDOW      (4),
    .PAYLOAD_BITS(16)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // link state as the block should hold it
  logic [SEQ_W-1:0]   send_seq;
  logic [SEQ_W-1:0]   rx_expect;
  logic [SEQ_W-1:0]   oldest;
  logic [SEQ_W-1:0]   in_flight;
  logic [15:0]        held_pay [SEQ_MOD];
  logic [TIMER_W-1:0] age [SEQ_MOD];
  logic [TIMER_W-1:0] tmo;

  link_res_t caused [$];
  link_res_t due_results [$];
  plan_row_t plan [$];

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;

  function automatic void link_reset();
    send_seq  = '0;
    rx_expect = '0;
    oldest    = '0;
    in_flight = '0;
    tmo       = TIMEOUT_RESET;
    for (int i = 0; i < SEQ_MOD; i++) begin
      held_pay[i] = '0;
      age[i]      = '0;
    end
  endfunction

  function automatic logic [SEQ_W-1:0] ack_now();
    return SEQ_W'((rx_expect + SEQ_MOD - 1) % SEQ_MOD);
  endfunction

  // works out the results of one accepted item and moves the link state on
  function automatic void step_link(input link_item_t it);
    int unsigned d;
    int unsigned s;
    bit fired;
    caused.delete();
    fired = 1'b0;
    case (it.op)
      OP_FRAME: begin
        if (it.rx_seq == rx_expect) begin
          caused.push_back(link_res_t'{KIND_DELIVER, 3'd0, 3'd0, it.payload, 1'b0});
          rx_expect = SEQ_W'((rx_expect + 1) % SEQ_MOD);
        end
        if (it.rx_ack < SEQ_MOD) begin
          d = (it.rx_ack + SEQ_MOD - oldest) % SEQ_MOD;
          // cumulative ack retires the named frame and all older ones
          if (d < in_flight) begin
            oldest    = SEQ_W'((oldest + d + 1) % SEQ_MOD);
            in_flight = SEQ_W'(in_flight - d - 1);
          end
        end
      end
      OP_SEND: begin
        if (in_flight < 4) begin
          s = send_seq;
          held_pay[s] = it.payload;
          age[s] = '0;
          caused.push_back(link_res_t'{KIND_TX, SEQ_W'(s), ack_now(), it.payload, 1'b0});
          send_seq  = SEQ_W'((s + 1) % SEQ_MOD);
          in_flight = in_flight + 1'b1;
        end else begin
          caused.push_back(link_res_t'{KIND_REFUSED, 3'd0, 3'd0, 16'd0, 1'b0});
        end
      end
      OP_TICK: begin
        for (int i = 0; i < in_flight; i++) begin
          s = (oldest + i) % SEQ_MOD;
          if (age[s] != TIMER_MAX) age[s] = age[s] + 1'b1;
          if (age[s] >= tmo) fired = 1'b1;
        end
        if (fired) begin
          for (int i = 0; i < in_flight; i++) begin
            s = (oldest + i) % SEQ_MOD;
            age[s] = '0;
            caused.push_back(link_res_t'{KIND_TX, SEQ_W'(s), ack_now(), held_pay[s], 1'b0});
          end
        end
      end
      default: ;
    endcase
    if (caused.size() > 0) caused[$].last = 1'b1;
  endfunction

  function automatic plan_row_t pred_row(input logic [OP_W-1:0] op, input logic [2:0] sq,
                                         input logic [2:0] ak, input logic [15:0] pl);
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.it      = link_item_t'{op, sq, ak, pl};
    r.typed   = 1'b0;
    r.has_res = 1'b0;
    r.res     = '0;
    r.tmo_val = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic [OP_W-1:0] op, input logic [2:0] sq,
                                          input logic [2:0] ak, input logic [15:0] pl,
                                          input bit has, input link_res_t res);
    plan_row_t r;
    r = pred_row(op, sq, ak, pl);
    r.typed   = 1'b1;
    r.has_res = has;
    r.res     = res;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [TIMER_W-1:0] v);
    plan_row_t r;
    r = pred_row(OP_IGNORED, 3'd0, 3'd0, 16'd0);
    r.is_cfg  = 1'b1;
    r.tmo_val = v;
    return r;
  endfunction

  // mostly well-formed traffic: in-order frames and acks naming frames in flight
  function automatic link_item_t rand_item();
    link_item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.payload = 16'($urandom);
    it.rx_seq  = 3'($urandom_range(0, 7));
    it.rx_ack  = 3'($urandom_range(0, 7));
    if (r < 5) begin
      it.op = OP_IGNORED;
    end else if (r < 40) begin
      it.op = OP_SEND;
    end else if (r < 75) begin
      it.op = OP_FRAME;
      if ($urandom_range(0, 9) < 6) it.rx_seq = rx_expect;
      if (in_flight > 0 && $urandom_range(0, 9) < 6)
        it.rx_ack = SEQ_W'((oldest + $urandom_range(0, in_flight - 1)) % SEQ_MOD);
    end else begin
      it.op = OP_TICK;
    end
    return it;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_timeout(input logic [TIMER_W-1:0] v);
    drain();
    // a tick without expiry leaves the block busy with no result to wait for
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tmo = v;
  endtask

  task automatic push_item(input link_item_t it, input bit typed, input bit has_res,
                           input link_res_t res);
    int unsigned gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 15) == 0) quiet_tx = ~quiet_tx;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= it.op;
    in_ch.rx_seq    <= it.rx_seq;
    in_ch.rx_ack    <= it.rx_ack;
    in_ch.payload   <= it.payload;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    step_link(it);
    if (typed) begin
      if (has_res) due_results.push_back(res);
    end else begin
      foreach (caused[i]) due_results.push_back(caused[i]);
    end
  endtask

  // result side
  initial begin
    int unsigned stall;
    link_res_t got;
    link_res_t want;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = quiet_rx ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 15) == 0) quiet_rx = ~quiet_rx;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (out_ch.valid !== 1'b1) @(posedge clk_i);
      got = link_res_t'{out_ch.kind, out_ch.tx_seq, out_ch.tx_ack, out_ch.out_payload,
                        out_ch.last};
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: kind %0d seq %0d ack %0d pay %h last %0d",
                   got.kind, got.seq, got.ack, got.pay, got.last);
      end else begin
        want = due_results.pop_front();
        if (got.kind !== want.kind || got.seq !== want.seq || got.ack !== want.ack ||
            got.pay !== want.pay || got.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected kind %0d seq %0d ack %0d pay %h last %0d, got %0d %0d %0d %h %0d",
                     want.kind, want.seq, want.ack, want.pay, want.last,
                     got.kind, got.seq, got.ack, got.pay, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [TIMER_W-1:0] phase_tmo [5];
    link_item_t it;
    int unsigned counted;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_data_i      <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_FRAME;
    in_ch.rx_seq    <= '0;
    in_ch.rx_ack    <= '0;
    in_ch.payload   <= '0;
    link_reset();

    // fill the window, overflow it, then walk delivery, acks and timeouts
    plan.push_back(typed_row(OP_SEND, 3'd0, 3'd0, 16'hFFFF, 1'b1,
                             link_res_t'{KIND_TX, 3'd0, 3'd4, 16'hFFFF, 1'b1}));
    plan.push_back(typed_row(OP_SEND, 3'd7, 3'd7, 16'h0000, 1'b1,
                             link_res_t'{KIND_TX, 3'd1, 3'd4, 16'h0000, 1'b1}));
    plan.push_back(pred_row(OP_SEND, 3'd0, 3'd0, 16'h1234));
    plan.push_back(pred_row(OP_SEND, 3'd0, 3'd0, 16'hA5A5));
    plan.push_back(typed_row(OP_SEND, 3'd0, 3'd0, 16'h5A5A, 1'b1,
                             link_res_t'{KIND_REFUSED, 3'd0, 3'd0, 16'h0000, 1'b1}));
    plan.push_back(typed_row(OP_TICK, 3'd0, 3'd0, 16'h0000, 1'b0, '0));
    plan.push_back(typed_row(OP_IGNORED, 3'd7, 3'd7, 16'hFFFF, 1'b0, '0));
    // ack out of range retires nothing
    plan.push_back(typed_row(OP_FRAME, 3'd0, 3'd7, 16'hBEEF, 1'b1,
                             link_res_t'{KIND_DELIVER, 3'd0, 3'd0, 16'hBEEF, 1'b1}));
    // sequence out of range, ack one past the window
    plan.push_back(pred_row(OP_FRAME, 3'd5, 3'd4, 16'h1111));
    plan.push_back(pred_row(OP_FRAME, 3'd7, 3'd1, 16'h2222));
    plan.push_back(cfg_row(20'd1));
    plan.push_back(pred_row(OP_TICK, 3'd0, 3'd0, 16'h0000));
    plan.push_back(pred_row(OP_SEND, 3'd0, 3'd0, 16'h0F0F));
    plan.push_back(pred_row(OP_SEND, 3'd0, 3'd0, 16'h7777));
    // full window resent from the oldest
    plan.push_back(pred_row(OP_TICK, 3'd0, 3'd0, 16'h0000));
    plan.push_back(cfg_row(20'd0));
    plan.push_back(pred_row(OP_FRAME, 3'd1, 3'd3, 16'h3333));
    plan.push_back(pred_row(OP_TICK, 3'd0, 3'd0, 16'h0000));
    plan.push_back(pred_row(OP_FRAME, 3'd2, 3'd0, 16'h4444));
    plan.push_back(typed_row(OP_TICK, 3'd0, 3'd0, 16'h0000, 1'b0, '0));
    plan.push_back(cfg_row(TIMER_MAX));
    plan.push_back(pred_row(OP_SEND, 3'd0, 3'd0, 16'h00FF));
    plan.push_back(pred_row(OP_TICK, 3'd0, 3'd0, 16'h0000));
    plan.push_back(pred_row(OP_FRAME, 3'd3, 3'd1, 16'hFF00));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_timeout(plan[i].tmo_val);
      else push_item(plan[i].it, plan[i].typed, plan[i].has_res, plan[i].res);
    end

    phase_tmo[0] = 20'd3;
    phase_tmo[1] = 20'd0;
    phase_tmo[2] = TIMER_MAX;
    phase_tmo[3] = 20'd1;
    phase_tmo[4] = 20'($urandom_range(2, 12));
    foreach (phase_tmo[p]) begin
      set_timeout(phase_tmo[p]);
      counted = 0;
      while (counted < PHASE_LEN) begin
        it = rand_item();
        // hold off until every outstanding item has come back
        if (counted == PHASE_LEN / 2 || $urandom_range(0, 29) == 0) drain();
        push_item(it, 1'b0, 1'b0, '0);
        if (it.op != OP_IGNORED) counted++;
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gbn_pkg.sv
rtl/gbn_in_if.sv
rtl/gbn_out_if.sv
rtl/gbn_timer_unit.sv
rtl/go_back_n_link_controller.sv
tb/go_back_n_link_controller_tb.sv
